### rtl/core/modular_exponentiation_macros.svh
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, held off while reset is low
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular exponentiation check failed");

// next-cycle implication, held off while reset is low
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular exponentiation check failed");

`endif

### rtl/core/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int OPERAND_BITS_DEFAULT = 31;

  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } mexp_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

### rtl/core/modular_exponentiation.sv
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_base_value
// out_      output     out_valid/out_ready  out_power_result, out_modulus_error
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// One transaction at a time; in_ready is high only while the sequencer is idle.
// A transaction runs one reduction of the base, then N squarings, N = OPERAND_BITS,
// and one multiply per set exponent bit, all on the single bit-serial modular multiplier.
// A zero modulus or zero exponent skips the multiplier and goes straight to done.
// The result register holds the last result until taken; a new transaction
// may be accepted meanwhile. Reset is synchronous; modulus resets to 1, exponent to 0.

module modular_exponentiation import mexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OPERAND_BITS-1:0]   in_base_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OPERAND_BITS-1:0]   out_power_result,
  output logic                      out_modulus_error,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [OPERAND_BITS-1:0]   cfg_wdata
);

  localparam int N     = OPERAND_BITS;
  localparam int IDX_W = $clog2(N);

  mexp_state_t state_r, state_nxt;

  logic [N-1:0]     modulus_r, exponent_r;
  logic [N-1:0]     acc_r, acc_nxt;
  logic [N-1:0]     base_r, base_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [N-1:0]     out_res_r, out_res_nxt;
  logic             out_err_r, out_err_nxt;

  logic             mm_start;
  logic [N-1:0]     mm_a, mm_b;
  logic [N-1:0]     mm_res;
  mm_status_t       mm_stat;

  logic             accept_w;
  logic             trivial_w;
  logic             last_bit_w;
  logic             out_free_w;

  assign accept_w   = in_valid && in_ready;
  assign trivial_w  = (modulus_r == '0) || (exponent_r == '0);
  assign last_bit_w = (idx_r == '0);
  assign out_free_w = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= N'(1);
      exponent_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_w) begin
          state_nxt = trivial_w ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          priority if (exponent_r[idx_r]) begin
            state_nxt = ST_MULT;
          end else if (last_bit_w) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SQUARE;
          end
        end
      end
      ST_MULT: begin
        if (mm_stat.done && last_bit_w) begin
          state_nxt = ST_DONE;
        end else if (mm_stat.done) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (out_free_w) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mm_start      = 1'b0;
    mm_a          = acc_r;
    mm_b          = acc_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    err_nxt       = err_r;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_w) begin
          idx_nxt = IDX_W'(N - 1);
          err_nxt = (modulus_r == '0);
          priority if (modulus_r == '0) begin
            acc_nxt = '0;
          end else if (exponent_r == '0) begin
            acc_nxt = N'(1);
          end else begin
            acc_nxt  = (modulus_r == N'(1)) ? '0 : N'(1);
            mm_start = 1'b1;
            mm_a     = N'(1);
            mm_b     = in_base_value;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          base_nxt = mm_res;
          mm_start = 1'b1;
        end
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          acc_nxt = mm_res;
          priority if (exponent_r[idx_r]) begin
            mm_start = 1'b1;
            mm_a     = mm_res;
            mm_b     = base_r;
          end else if (!last_bit_w) begin
            idx_nxt  = idx_r - IDX_W'(1);
            mm_start = 1'b1;
            mm_a     = mm_res;
            mm_b     = mm_res;
          end else begin
            mm_start = 1'b0;
          end
        end
      end
      ST_MULT: begin
        if (mm_stat.done) begin
          acc_nxt = mm_res;
          if (!last_bit_w) begin
            idx_nxt  = idx_r - IDX_W'(1);
            mm_start = 1'b1;
            mm_a     = mm_res;
            mm_b     = mm_res;
          end
        end
      end
      ST_DONE: begin
        if (out_free_w) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = acc_r;
          out_err_nxt   = err_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    idx_r     <= idx_nxt;
    err_r     <= err_nxt;
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
  end

  mexp_modmul #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .op_a   (mm_a),
    .op_b   (mm_b),
    .op_m   (modulus_r),
    .status (mm_stat),
    .result (mm_res)
  );

  assign out_valid         = out_valid_r;
  assign out_power_result  = out_res_r;
  assign out_modulus_error = out_err_r;

  `MEXP_ASSERT_IMP(a_err_gives_zero, clk, rst_n, out_valid_r && out_err_r, out_res_r == '0)
  `MEXP_ASSERT_NXT(a_start_makes_busy, clk, rst_n, mm_start, mm_stat.busy)
  `MEXP_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE))

endmodule

### rtl/core/mexp_modmul.sv
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"

module mexp_modmul import mexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [OPERAND_BITS-1:0] op_a,
  input  logic [OPERAND_BITS-1:0] op_b,
  input  logic [OPERAND_BITS-1:0] op_m,
  output mm_status_t              status,
  output logic [OPERAND_BITS-1:0] result
);

  localparam int N     = OPERAND_BITS;
  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     a_r, b_r, m_r, acc_r;
  logic [N-1:0]     a_nxt, b_nxt, m_nxt, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [N:0]   dbl_w;
  logic [N:0]   red_w;
  logic [N:0]   sum_w;
  logic [N:0]   fin_w;

  // one add-and-double step: acc = 2*acc mod m, then + a mod m when the bit is set
  always_comb begin
    dbl_w = {acc_r, 1'b0};
    red_w = (dbl_w >= {1'b0, m_r}) ? (dbl_w - {1'b0, m_r}) : dbl_w;
    sum_w = {1'b0, red_w[N-1:0]} + {1'b0, a_r};
    if (b_r[N-1]) begin
      fin_w = (sum_w >= {1'b0, m_r}) ? (sum_w - {1'b0, m_r}) : sum_w;
    end else begin
      fin_w = red_w;
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      m_nxt    = op_m;
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = fin_w[N-1:0];
      b_nxt   = {b_r[N-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign result      = acc_r;

  `MEXP_ASSERT_IMP(a_acc_below_mod, clk, rst_n, busy_r, acc_r < m_r)
  `MEXP_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_r, !busy_r)

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mexp_pkg::*;

  localparam int N = OPERAND_BITS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [N-1:0] TOP = '1;

  typedef enum logic {STEP_BASE, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t                kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [N-1:0]              value;
    int unsigned               gap;
    bit                        rx_stalls;
  } step_t;

  typedef struct packed {
    logic [N-1:0] power;
    logic         err;
  } power_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [N-1:0]              in_base_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [N-1:0]              out_power_result;
  logic                      out_modulus_error;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MODULUS;
  logic [N-1:0]              cfg_wdata = '0;

  logic [N-1:0] model_modulus = N'(1);
  logic [N-1:0] model_exponent = '0;

  step_t  exchange_plan[$];
  power_t pending_powers[$];

  int          mismatches = 0;
  int          results_seen = 0;
  int          error_results = 0;
  int          unit_results = 0;
  int          writes_done = 0;
  int          idle_cycles = 0;
  bit          in_taken = 1'b0;
  bit          rx_stalls = 1'b0;
  bit          jitter_on = 1'b1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned settle = 0;

  modular_exponentiation #(.OPERAND_BITS(N)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_base_value     (in_base_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_power_result  (out_power_result),
    .out_modulus_error (out_modulus_error),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic power_t predict_power(logic [N-1:0] base, logic [N-1:0] m,
                                           logic [N-1:0] e);
    logic [63:0] mm;
    logic [63:0] b;
    logic [63:0] acc;
    power_t      r;
    r.power = '0;
    r.err = 1'b0;
    if (m == '0) begin
      r.err = 1'b1;
      return r;
    end
    if (e == '0) begin
      r.power = N'(1);
      return r;
    end
    mm = 64'(m);
    b = 64'(base) % mm;
    acc = 64'd1 % mm;
    for (int i = N - 1; i >= 0; i--) begin
      acc = (acc * acc) % mm;
      if (e[i]) begin
        acc = (acc * b) % mm;
      end
    end
    r.power = acc[N-1:0];
    return r;
  endfunction

  task automatic add_write(logic [CFG_INDEX_BITS-1:0] index, logic [N-1:0] value);
    step_t s;
    s.kind = STEP_WRITE;
    s.index = index;
    s.value = value;
    s.gap = 0;
    s.rx_stalls = jitter_on;
    exchange_plan.push_back(s);
  endtask

  task automatic add_base(logic [N-1:0] value);
    step_t s;
    s.kind = STEP_BASE;
    s.index = REG_MODULUS;
    s.value = value;
    s.gap = (jitter_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    s.rx_stalls = jitter_on;
    exchange_plan.push_back(s);
  endtask

  function automatic logic [N-1:0] pick_modulus();
    logic [N-1:0] v;
    case ($urandom_range(0, 5))
      3: v = N'($urandom_range(2, 65535));
      4: v = TOP;
      5: v = N'($urandom_range(1, 3));
      default: v = N'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [N-1:0] pick_exponent();
    logic [N-1:0] v;
    case ($urandom_range(0, 5))
      4: v = N'($urandom_range(1, 255));
      5: v = TOP;
      default: v = N'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [N-1:0] pick_base(logic [N-1:0] m);
    logic [N-1:0] v;
    v = N'($urandom());
    case ($urandom_range(0, 7))
      3: v = (m == '0) ? v : v % m;
      4: v = N'($urandom_range(0, 15));
      5: v = m;
      6: v = m - N'(1);
      7: v = $urandom_range(0, 1) ? TOP : '0;
      default: ;
    endcase
    return v;
  endfunction

  // drive transactions and configuration writes; drain before every write
  always @(negedge clk) begin
    logic  next_valid;
    logic  next_we;
    step_t head;
    next_valid = in_valid && !in_taken;
    next_we = 1'b0;
    if (rst_n && !next_valid) begin
      settle = (pending_powers.size() == 0) ? settle + 1 : 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (exchange_plan.size() > 0) begin
        head = exchange_plan[0];
        if (head.kind == STEP_BASE) begin
          head = exchange_plan.pop_front();
          next_valid = 1'b1;
          in_base_value <= head.value;
          gap_left = head.gap;
          rx_stalls = head.rx_stalls;
        end else if (settle >= 3) begin
          head = exchange_plan.pop_front();
          next_we = 1'b1;
          cfg_index <= head.index;
          cfg_wdata <= head.value;
          if (head.index == REG_MODULUS) begin
            model_modulus = head.value;
          end else begin
            model_exponent = head.value;
          end
          writes_done++;
        end
      end
    end
    in_valid <= next_valid;
    cfg_we <= next_we;

    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_stalls && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
    end
  end

  // check results against the oldest prediction, then record new transactions
  always @(posedge clk) begin
    power_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_powers.size() == 0) begin
          mismatches++;
          $error("unexpected result: power_result %0d, modulus_error %0b",
                 out_power_result, out_modulus_error);
        end else begin
          want = pending_powers.pop_front();
          if (want.err) begin
            error_results++;
          end
          if (!want.err && want.power == N'(1)) begin
            unit_results++;
          end
          if (out_power_result !== want.power) begin
            mismatches++;
            $error("power_result: expected %0d, got %0d", want.power, out_power_result);
          end
          if (out_modulus_error !== want.err) begin
            mismatches++;
            $error("modulus_error: expected %0b, got %0b", want.err, out_modulus_error);
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_powers.push_back(predict_power(in_base_value, model_modulus,
                                               model_exponent));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [N-1:0] m;
    logic [N-1:0] e;

    // reset values: modulus one, exponent zero
    add_base('0);
    add_base(TOP);
    add_write(REG_MODULUS, '0);
    add_write(REG_EXPONENT, N'(5));
    add_base('0);
    add_base(N'(12345));
    add_write(REG_EXPONENT, '0);
    add_base(TOP);
    add_write(REG_MODULUS, TOP);
    add_write(REG_EXPONENT, TOP);
    add_base('0);
    add_base(N'(1));
    add_base(N'(2));
    add_base(TOP);
    add_base(TOP - N'(1));
    add_write(REG_MODULUS, N'(1));
    add_write(REG_EXPONENT, N'(3));
    add_base(N'(9));
    add_write(REG_MODULUS, N'(23));
    add_write(REG_EXPONENT, N'(6));
    add_base(N'(5));
    add_base(N'(5 + 23 * 1000));
    add_write(REG_MODULUS, N'(2));
    add_write(REG_EXPONENT, N'(1));
    add_base(N'(3));
    add_base(TOP);

    for (int phase = 0; phase < 13; phase++) begin
      jitter_on = (phase % 4 != 2) && (phase < 11);
      m = (phase == 4) ? '0 : pick_modulus();
      e = (phase == 8) ? '0 : pick_exponent();
      if ($urandom_range(0, 1)) begin
        add_write(REG_MODULUS, m);
        add_write(REG_EXPONENT, e);
      end else begin
        add_write(REG_EXPONENT, e);
        add_write(REG_MODULUS, m);
      end
      for (int k = 0; k < 20; k++) begin
        add_base(pick_base(m));
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (exchange_plan.size() == 0 && !in_valid);
    wait (pending_powers.size() == 0);
    repeat (50) @(posedge clk);

    $display("Checked %0d modular powers across %0d register writes.",
             results_seen, writes_done);
    $display("Of these %0d flagged a zero modulus and %0d came out as one.",
             error_results, unit_results);
    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
